FILE: design/b64e_pkg.sv
`default_nettype none
package b64e_pkg;

   localparam logic [7:0] PAD_CHAR    = 8'h3D;
   localparam logic [5:0] SEXTET_MASK = 6'h3F;

   // index of the closing character within a four character group
   localparam logic [1:0] LAST_POS = 2'd3;

   // one group of up to three bytes, msb byte first, missing bytes zero
   typedef struct packed {
      logic [23:0] bits;
      logic [1:0]  nbytes;
      logic        last;
   } group_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] s);
      logic [7:0] c;
      c = 8'h00;
      case (s) inside
         [6'd0:6'd25]:  c = 8'd65 + {2'b00, s};
         [6'd26:6'd51]: c = 8'd97 + {2'b00, s} - 8'd26;
         [6'd52:6'd61]: c = 8'd48 + {2'b00, s} - 8'd52;
         6'd62:         c = 8'h2B;
         6'd63:         c = 8'h2F;
         default:       c = 8'h00;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: design/b64e_front.sv
`default_nettype none
module b64e_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  req_final_byte,
   input  wire logic                  q_full,
   output logic                       q_push,
   output b64e_pkg::group_type        q_data
);

   logic [15:0] pend_ff, pend_in;
   logic [1:0]  count_ff, count_in;
   logic        accept;
   logic        closes;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign closes    = req_final_byte || (count_ff >= 2'd2);
   assign q_push    = accept && closes;

   always_comb begin
      q_data.last = req_final_byte;
      case (count_ff)
         2'd0: begin
            q_data.bits   = {req_data_byte, 16'h0000};
            q_data.nbytes = 2'd1;
         end
         2'd1: begin
            q_data.bits   = {pend_ff[7:0], req_data_byte, 8'h00};
            q_data.nbytes = 2'd2;
         end
         default: begin
            // a count of three cannot occur and acts as two
            q_data.bits   = {pend_ff, req_data_byte};
            q_data.nbytes = 2'd3;
         end
      endcase
   end

   always_comb begin
      pend_in  = pend_ff;
      count_in = count_ff;
      if (accept) begin
         if (closes) begin
            pend_in  = 16'h0000;
            count_in = 2'd0;
         end else begin
            pend_in  = {pend_ff[7:0], req_data_byte};
            count_in = count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 16'h0000;
         count_ff <= 2'd0;
      end else begin
         pend_ff  <= pend_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/b64e_queue.sv
`default_nettype none
module b64e_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire b64e_pkg::group_type   push_data,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       not_empty,
   output b64e_pkg::group_type        head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64e_pkg::group_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: design/b64e_back.sv
`default_nettype none
module b64e_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_not_empty,
   input  wire b64e_pkg::group_type   q_head,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [7:0]                 rsp_out_char,
   output logic                       rsp_group_end,
   output logic                       rsp_message_end
);

   b64e_pkg::group_type grp_ff, grp_in;
   logic [1:0] pos_ff, pos_in;
   logic       busy_ff, busy_in;
   logic       fire;
   logic       at_last;
   logic [5:0] sextet;
   logic       pad;

   assign rsp_valid = busy_ff;
   assign fire      = busy_ff && rsp_ready;
   assign at_last   = (pos_ff == b64e_pkg::LAST_POS);
   // next group loads as the closing character leaves, so queued groups run gapless
   assign q_pop     = q_not_empty && (!busy_ff || (fire && at_last));

   always_comb begin
      case (pos_ff)
         2'd0:    sextet = grp_ff.bits[23:18];
         2'd1:    sextet = grp_ff.bits[17:12];
         2'd2:    sextet = grp_ff.bits[11:6];
         default: sextet = grp_ff.bits[5:0];
      endcase
      sextet = sextet & b64e_pkg::SEXTET_MASK;
      pad = ((pos_ff == 2'd2) && (grp_ff.nbytes < 2'd2))
         || ((pos_ff == 2'd3) && (grp_ff.nbytes < 2'd3));
   end

   assign rsp_out_char    = pad ? b64e_pkg::PAD_CHAR : b64e_pkg::sextet_char(sextet);
   assign rsp_group_end   = at_last;
   assign rsp_message_end = at_last && grp_ff.last;

   always_comb begin
      grp_in  = grp_ff;
      pos_in  = pos_ff;
      busy_in = busy_ff;
      if (q_pop) begin
         grp_in  = q_head;
         pos_in  = 2'd0;
         busy_in = 1'b1;
      end else if (fire) begin
         if (at_last) begin
            busy_in = 1'b0;
            pos_in  = 2'd0;
         end else begin
            pos_in = pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   a_mend_closes_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_end |-> rsp_group_end)
      else $error("message end off a group end");

   a_no_early_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (pos_ff == 2'd0 || pos_ff == 2'd1) |-> rsp_out_char != b64e_pkg::PAD_CHAR)
      else $error("padding in a leading position");

   a_idle_when_drained: assert property (@(posedge clock) disable iff (reset)
      fire && at_last && !q_not_empty |=> !busy_ff)
      else $error("output stays busy with nothing queued");

   a_pos_only_busy: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> pos_ff == 2'd0)
      else $error("character position moved while idle");

endmodule
`default_nettype wire

FILE: design/base64_stream_encoder.sv
`default_nettype none
// path: the first character of a group is offered once the group has passed through the group
// queue and the output group register
// throughput: one byte per cycle while the group queue has room, one character per cycle
// out while rsp_ready is high; the output port sets the rate: 4 characters per 3-byte group
// reset: synchronous active high, clears the pending bytes, the group queue and the output
// sequencer; no clearing pass, the block accepts bytes in the first cycle after reset
module base64_stream_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_final_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_group_end,
   output logic             rsp_message_end
);

   b64e_pkg::group_type push_data;
   b64e_pkg::group_type head;
   logic q_push;
   logic q_full;
   logic q_pop;
   logic q_not_empty;

   b64e_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (push_data)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (head)
   );

   b64e_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_not_empty     (q_not_empty),
      .q_head          (head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_group_end   (rsp_group_end),
      .rsp_message_end (rsp_message_end)
   );

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_DIRECTED   = 21;
   localparam int HOLD_CYCLES    = 80;
   localparam int STALL_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int IDLE_PERCENT   = 28;

   // standard alphabet, index 0 sits in the most significant byte
   localparam logic [0:63][7:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        typed;
      logic [31:0] text;
   } directed_row_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       group_end;
      logic       message_end;
   } char_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_char;
   logic        rsp_group_end;
   logic        rsp_message_end;

   // typed expectation travels with the beat on the input side
   logic        beat_typed = 1'b0;
   logic [31:0] beat_text = 32'h0;

   logic [15:0] held_bytes = 16'h0;
   logic [1:0]  held_count = 2'd0;
   char_beat_type expected_chars [$];

   int  error_count = 0;
   int  bytes_sent = 0;
   int  messages_sent = 0;
   int  chars_checked = 0;
   int  padded_groups = 0;
   int  quiet_cycles = 0;
   bit  sender_idles = 1'b1;
   bit  receiver_idles = 1'b1;
   bit  hold_requested = 1'b0;

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{8'h00, 1'b1, 1'b1, "AA=="},
      '{8'hFF, 1'b1, 1'b1, "/w=="},
      '{8'h00, 1'b0, 1'b0, 32'h0},
      '{8'h00, 1'b1, 1'b1, "AAA="},
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'hFF, 1'b1, 1'b1, "//8="},
      '{8'h00, 1'b0, 1'b0, 32'h0},
      '{8'h00, 1'b0, 1'b0, 32'h0},
      '{8'h00, 1'b0, 1'b1, "AAAA"},
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'hFF, 1'b0, 1'b1, "////"},
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'hFF, 1'b1, 1'b1, "////"},
      '{8'h4D, 1'b0, 1'b0, 32'h0},
      '{8'h61, 1'b0, 1'b0, 32'h0},
      '{8'h6E, 1'b0, 1'b0, 32'h0},
      '{8'h4D, 1'b0, 1'b0, 32'h0},
      '{8'h61, 1'b1, 1'b0, 32'h0},
      '{8'h80, 1'b1, 1'b0, 32'h0}
   };

   base64_stream_encoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_final_byte  (req_final_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_group_end   (rsp_group_end),
      .rsp_message_end (rsp_message_end)
   );

   always #5 clock = ~clock;

   // absorb one byte, queue the four characters of any group it closes
   task automatic encode_byte(input logic [7:0] b, input logic last, input logic typed,
                              input logic [31:0] text);
      logic [23:0] grp;
      logic [7:0]  ch [4];
      int          n;
      char_beat_type beat;
      if (!last && held_count < 2'd2) begin
         held_bytes = {held_bytes[7:0], b};
         held_count = held_count + 2'd1;
      end else begin
         n = int'(held_count) + 1;
         case (held_count)
            2'd0: grp = {b, 16'h0000};
            2'd1: grp = {held_bytes[7:0], b, 8'h00};
            default: grp = {held_bytes, b};
         endcase
         ch[0] = ALPHABET[grp[23:18]];
         ch[1] = ALPHABET[grp[17:12]];
         ch[2] = (n >= 2) ? ALPHABET[grp[11:6]] : b64e_pkg::PAD_CHAR;
         ch[3] = (n >= 3) ? ALPHABET[grp[5:0]] : b64e_pkg::PAD_CHAR;
         if (n < 3)
            padded_groups++;
         for (int k = 0; k < 4; k++) begin
            beat.out_char    = typed ? text[31 - 8 * k -: 8] : ch[k];
            beat.group_end   = (k == 3);
            beat.message_end = (k == 3) && last;
            expected_chars.push_back(beat);
         end
         held_bytes = 16'h0000;
         held_count = 2'd0;
      end
   endtask

   always @(posedge clock) begin
      char_beat_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            encode_byte(req_data_byte, req_final_byte, beat_typed, beat_text);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected character beat 0x%02h", rsp_out_char);
               error_count++;
            end else begin
               want = expected_chars.pop_front();
               chars_checked++;
               if (rsp_out_char !== want.out_char) begin
                  $error("out_char: expected 0x%02h, got 0x%02h", want.out_char, rsp_out_char);
                  error_count++;
               end
               if (rsp_group_end !== want.group_end) begin
                  $error("group_end: expected %0d, got %0d", want.group_end, rsp_group_end);
                  error_count++;
               end
               if (rsp_message_end !== want.message_end) begin
                  $error("message_end: expected %0d, got %0d", want.message_end,
                         rsp_message_end);
                  error_count++;
               end
            end
         end
      end
   end

   // stall watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: random back-pressure plus one long hold-off on request
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_requested) begin
            hold_requested = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_ready <= !(receiver_idles && $urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                            input logic [31:0] text);
      while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_final_byte <= last;
      beat_typed     <= typed;
      beat_text      <= text;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      if (last)
         messages_sent++;
   endtask

   task automatic send_message(input int len);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(9))
            0: b = 8'h00;
            1: b = 8'hFF;
            default: b = 8'($urandom_range(255));
         endcase
         send_byte(b, i == len - 1, 1'b0, 32'h0);
      end
   endtask

   function automatic int pick_length();
      return ($urandom_range(3) == 0) ? int'($urandom_range(12, 4)) : int'($urandom_range(3, 1));
   endfunction

   task automatic send_random_bytes(input int count);
      int goal;
      goal = bytes_sent + count;
      while (bytes_sent < goal)
         send_message(pick_length());
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                   directed_rows[i].text);

      send_random_bytes(70);

      // long receiver hold-off while bytes keep coming, so the input stalls
      hold_requested = 1'b1;
      sender_idles = 1'b0;
      send_message(15);
      send_message(2);
      sender_idles = 1'b1;

      // let everything drain before going on
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);

      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      send_random_bytes(60);
      sender_idles = 1'b1;
      receiver_idles = 1'b1;

      send_random_bytes(70);
      req_valid <= 1'b0;

      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d bytes in %0d messages, %0d characters checked, %0d padded groups",
               bytes_sent, messages_sent, chars_checked, padded_groups);
      $display("including a long output hold-off, a full drain and a stretch at full rate");
      if (error_count == 0 && expected_chars.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
design/b64e_pkg.sv
design/b64e_front.sv
design/b64e_queue.sv
design/b64e_back.sv
design/base64_stream_encoder.sv
dv/testbench.sv
